// ===== design/bru_pkg.sv =====
// Shared types, constants and helpers for the beacon route update block.
package bru_pkg;

  localparam int SEEN_DEPTH = 16;
  localparam int SEEN_AW    = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;

  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 8;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;

  // Input tdata field positions.
  localparam int IN_MODE_LO   = 0;
  localparam int IN_SEND_BIT  = 2;
  localparam int IN_CLEAN_BIT = 3;
  localparam int IN_HOPS_LO   = 4;
  localparam int IN_STAMP_LO  = 12;
  localparam int IN_ID_LO     = 44;
  localparam int IN_COST_LO   = 60;
  localparam int IN_SNDR_LO   = 68;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BEACON_TYPE = 2'd0,
    CFG_HOP_MARGIN  = 2'd1,
    CFG_LINK_COST   = 2'd2
  } cfg_idx_t;

  // Node radio modes.
  typedef enum logic [1:0] {
    MODE_SLEEP  = 2'd0,
    MODE_LISTEN = 2'd1,
    MODE_COMM   = 2'd2,
    MODE_TX     = 2'd3
  } node_mode_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_NOT_LISTENING = 3'd0,
    ST_INTERFERENCE  = 3'd1,
    ST_WRONG_TYPE    = 3'd2,
    ST_JOINED        = 3'd3,
    ST_NEW_BEACON    = 3'd4,
    ST_DUPLICATE     = 3'd5,
    ST_OUT_OF_RANGE  = 3'd6
  } rx_status_t;

  // Controller states.
  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_CALC = 1'b1
  } fsm_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture an input beat and look up its packet id
    logic commit;  // update route state and write the result register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // result register can take a new result this cycle
  } dp_stat_t;

  function automatic logic [7:0] sat_add8(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8] ? 8'hFF : s[7:0];
  endfunction

endpackage

// ===== design/bru_ctrl.sv =====
// Controller state machine for the beacon route update block.
module bru_ctrl
  import bru_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FSM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_tvalid) state_nxt = FSM_CALC;
      end
      FSM_CALC: begin
        if (stat.out_free) state_nxt = FSM_IDLE;
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      FSM_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      FSM_CALC: begin
        cmd.commit = stat.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

// ===== design/bru_dp.sv =====
// Datapath for the beacon route update block: route state, id ring, result register.
module bru_dp
  import bru_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctrl_cmd_t              cmd,
  output dp_stat_t               stat,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  // Configuration.
  logic [7:0] beacon_type_r, hop_margin_r, link_cost_r;

  // Captured beat.
  logic [1:0]  mode_r;
  logic        sending_r, clean_r;
  logic [7:0]  mtype_r, mhops_r, mcost_r;
  logic [31:0] mstamp_r;
  logic [15:0] mid_r, msender_r;
  logic [SEEN_DEPTH-1:0] hit_r;

  // Route state.
  logic        joined_r, joined_nxt;
  logic [7:0]  own_hops_r, own_hops_nxt, own_cost_r, own_cost_nxt;
  logic [15:0] parent_r, parent_nxt;
  logic [31:0] stamp_r, stamp_nxt;

  // Recently seen packet ids.
  logic [15:0]           seen_ids_r [SEEN_DEPTH];
  logic [SEEN_DEPTH-1:0] seen_valid_r;
  logic [SEEN_AW-1:0]    seen_ptr_r;
  logic                  push;

  // Result register.
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [OUT_TUSER_W-1:0] out_tuser_r;
  rx_status_t             status;

  logic [15:0] in_id;
  logic        can_rx, good, same, reload, switch_hop, window, hit;
  logic [7:0]  sat_hops, sat_cost;
  logic        changed, rebcast, clr;
  logic [15:0] old_hop;

  assign in_id = in_tdata[IN_ID_LO +: 16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beacon_type_r <= 8'd0;
      hop_margin_r  <= 8'd4;
      link_cost_r   <= 8'd5;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_BEACON_TYPE: beacon_type_r <= cfg_data;
        CFG_HOP_MARGIN:  hop_margin_r  <= cfg_data;
        CFG_LINK_COST:   link_cost_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the beat and compare its id against every ring entry in parallel.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r    <= in_tdata[IN_MODE_LO +: 2];
      sending_r <= in_tdata[IN_SEND_BIT];
      clean_r   <= in_tdata[IN_CLEAN_BIT];
      mhops_r   <= in_tdata[IN_HOPS_LO +: 8];
      mstamp_r  <= in_tdata[IN_STAMP_LO +: 32];
      mid_r     <= in_id;
      mcost_r   <= in_tdata[IN_COST_LO +: 8];
      msender_r <= in_tdata[IN_SNDR_LO +: 16];
      mtype_r   <= in_tuser;
      for (int i = 0; i < SEEN_DEPTH; i++) begin
        hit_r[i] <= seen_valid_r[i] && (seen_ids_r[i] == in_id);
      end
    end
  end

  always_comb begin
    can_rx = (node_mode_t'(mode_r) == MODE_LISTEN) ||
             ((node_mode_t'(mode_r) == MODE_COMM) && !sending_r);
    good     = can_rx && clean_r && (mtype_r == beacon_type_r);
    sat_hops = sat_add8(mhops_r, 8'd1);
    sat_cost = sat_add8(mcost_r, link_cost_r);
    same     = (parent_r == msender_r);
    reload   = same ? (own_cost_r < mcost_r) : (own_cost_r > mcost_r);
    switch_hop = !same && (own_cost_r > mcost_r);
    hit      = |hit_r;

    joined_nxt   = joined_r;
    own_hops_nxt = own_hops_r;
    own_cost_nxt = own_cost_r;
    parent_nxt   = parent_r;
    stamp_nxt    = stamp_r;
    changed = 1'b0;
    rebcast = 1'b0;
    clr     = 1'b0;
    old_hop = 16'd0;
    push    = 1'b0;
    window  = 1'b0;

    if (!can_rx) begin
      status = ST_NOT_LISTENING;
    end else if (!clean_r) begin
      status = ST_INTERFERENCE;
    end else if (mtype_r != beacon_type_r) begin
      status = ST_WRONG_TYPE;
    end else if (!joined_r) begin
      joined_nxt   = 1'b1;
      own_hops_nxt = sat_hops;
      own_cost_nxt = sat_cost;
      parent_nxt   = msender_r;
      stamp_nxt    = mstamp_r;
      push    = 1'b1;
      rebcast = 1'b1;
      changed = 1'b1;
      status  = ST_JOINED;
    end else begin
      if (reload) begin
        own_hops_nxt = sat_hops;
        own_cost_nxt = sat_cost;
      end
      if (switch_hop) begin
        old_hop    = parent_r;
        parent_nxt = msender_r;
        changed    = 1'b1;
      end
      // Window test uses the hop count after any reload, without wrap.
      window = ({1'b0, own_hops_nxt} + {1'b0, hop_margin_r}) > {1'b0, mhops_r};
      if (window) begin
        stamp_nxt = mstamp_r;
        if (hit) begin
          status = ST_DUPLICATE;
        end else begin
          push    = 1'b1;
          rebcast = 1'b1;
          clr     = 1'b1;
          status  = ST_NEW_BEACON;
        end
      end else begin
        status = ST_OUT_OF_RANGE;
      end
    end

    out_tdata_nxt = {5'd0, clr, rebcast, stamp_nxt, own_cost_nxt, own_hops_nxt,
                     parent_nxt, old_hop, changed, msender_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joined_r     <= 1'b0;
      own_hops_r   <= 8'd0;
      own_cost_r   <= 8'd0;
      parent_r     <= 16'd0;
      stamp_r      <= 32'd0;
      seen_valid_r <= '0;
      seen_ptr_r   <= '0;
    end else if (cmd.commit && good) begin
      joined_r   <= joined_nxt;
      own_hops_r <= own_hops_nxt;
      own_cost_r <= own_cost_nxt;
      parent_r   <= parent_nxt;
      stamp_r    <= stamp_nxt;
      if (push) begin
        seen_valid_r[seen_ptr_r] <= 1'b1;
        if (seen_ptr_r == SEEN_AW'(SEEN_DEPTH - 1)) begin
          seen_ptr_r <= '0;
        end else begin
          seen_ptr_r <= seen_ptr_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && push) begin
      seen_ids_r[seen_ptr_r] <= mid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= status;
    end
  end

  assign stat.out_free = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_tdata_r;
  assign out_tuser     = out_tuser_r;

endmodule

// ===== design/beacon_route_update_core.sv =====
// Top level of the beacon route update block.
//
// The block takes one received flooding beacon per input beat and returns one
// result beat per input beat, in order. An input beat moves on in_tvalid and
// in_tready; in_tdata holds the radio state and beacon contents and in_tuser
// the message type byte. The result beat moves on out_tvalid and out_tready;
// out_tuser holds the status code and out_tdata the route state after the beat.
// Configuration writes use cfg_valid, cfg_index and cfg_data and are always
// taken; index 0 is the beacon type, 1 the hop margin, 2 the link cost, and
// other indexes are ignored.
// Each beat is first captured and its packet id compared against the sixteen
// entries of the seen-id ring in parallel; then, once the result register is
// free, the route and the ring are updated and out_tvalid rises. No new input
// beat is accepted until that update is done.
// The result sits in an output register, so a new input beat is accepted while
// an earlier result waits. If the receiver stalls and the register is still
// full, the block holds the pending beat in its compute state and accepts no
// input until the register frees. Synchronous reset clears the route state,
// the ring valid bits and write pointer and the output valid, and sets the
// configuration to type 0, margin 4, link cost 5; no clearing pass is needed.
module beacon_route_update_core
  import bru_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [1:0] node_mode, [2] sending_in_window, [3] interference_free,
  // [11:4] msg_hop_count, [43:12] msg_time_stamp, [59:44] msg_packet_id,
  // [67:60] msg_path_cost, [83:68] msg_sender, [87:84] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [7:0] msg_type
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] report_sender, [16] route_changed, [32:17] old_next_hop,
  // [48:33] next_hop, [56:49] route_hops, [64:57] route_cost,
  // [96:65] sync_time, [97] rebroadcast, [98] clear_slots, [103:99] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [2:0] status
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Configuration registers are plain flops, so writes never wait.
  assign cfg_ready = 1'b1;

  bru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bru_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the beacon route update core: directed and random beacons.
`timescale 1ns / 1ps

module tb_top
  import bru_pkg::*;
;

  localparam int CLK_PERIOD = 20;
  localparam int RESET_CYCLES = 8;
  // Generous ceiling for roughly 1700 beats.
  localparam int RUN_LIMIT_CYCLES = 200_000;
  // The receiver's long hold-off, in cycles, long enough to back the block up fully.
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_PERCENT = 26;
  // Index 3 is not a register; a write there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  // Input beat layout, lowest field last, matching in_tdata.
  typedef struct packed {
    logic [3:0]  pad;
    logic [15:0] sender;
    logic [7:0]  cost;
    logic [15:0] packet_id;
    logic [31:0] stamp;
    logic [7:0]  hops;
    logic        clean;
    logic        sending;
    node_mode_t  mode;
  } rx_word_t;

  // Result beat layout, matching out_tdata.
  typedef struct packed {
    logic [4:0]  pad;
    logic        clear_slots;
    logic        rebroadcast;
    logic [31:0] sync_time;
    logic [7:0]  route_cost;
    logic [7:0]  route_hops;
    logic [15:0] next_hop;
    logic [15:0] old_next_hop;
    logic        route_changed;
    logic [15:0] report_sender;
  } route_word_t;

  typedef struct {
    rx_status_t  status;
    route_word_t data;
  } route_report_t;

  // Route table predictor plus the store of route reports still owed by the block.
  class route_scoreboard;
    logic [7:0]  type_code;
    logic [7:0]  margin;
    logic [7:0]  link;
    bit          joined;
    logic [7:0]  hops;
    logic [7:0]  cost;
    logic [15:0] parent;
    logic [31:0] stamp;
    logic [15:0] recent_ids[SEEN_DEPTH];
    bit          recent_ok[SEEN_DEPTH];
    int          wr_slot;
    route_report_t pending_reports[$];
    int          faults;

    function new();
      type_code = 8'd0;
      margin    = 8'd4;
      link      = 8'd5;
      joined    = 0;
      hops      = '0;
      cost      = '0;
      parent    = '0;
      stamp     = '0;
      wr_slot   = 0;
      faults    = 0;
      foreach (recent_ok[i]) recent_ok[i] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
      case (idx)
        CFG_BEACON_TYPE: type_code = value;
        CFG_HOP_MARGIN:  margin = value;
        CFG_LINK_COST:   link = value;
        default: ;
      endcase
    endfunction

    local function logic [7:0] clamp_add(logic [7:0] a, logic [7:0] b);
      return (a > 8'd255 - b) ? 8'd255 : a + b;
    endfunction

    local function bit id_known(logic [15:0] id);
      for (int i = 0; i < SEEN_DEPTH; i++)
        if (recent_ok[i] && recent_ids[i] == id) return 1;
      return 0;
    endfunction

    // The ring overwrites its oldest entry once all slots are in use.
    local function void remember_id(logic [15:0] id);
      recent_ids[wr_slot] = id;
      recent_ok[wr_slot]  = 1;
      wr_slot = (wr_slot + 1) % SEEN_DEPTH;
    endfunction

    function void fault(string msg);
      faults++;
      if (faults <= 10) $display("%s", msg);
    endfunction

    // Predicts the route report for one accepted beacon and updates the route state.
    function void note_beat(rx_word_t w, logic [7:0] mtype);
      route_report_t r;
      bit can_hear;
      r.data = '0;
      can_hear = (w.mode == MODE_LISTEN) || (w.mode == MODE_COMM && !w.sending);
      if (!can_hear) begin
        r.status = ST_NOT_LISTENING;
      end else if (!w.clean) begin
        r.status = ST_INTERFERENCE;
      end else if (mtype != type_code) begin
        r.status = ST_WRONG_TYPE;
      end else if (!joined) begin
        joined = 1;
        hops   = clamp_add(w.hops, 8'd1);
        cost   = clamp_add(w.cost, link);
        parent = w.sender;
        stamp  = w.stamp;
        remember_id(w.packet_id);
        r.data.rebroadcast   = 1'b1;
        r.data.route_changed = 1'b1;
        r.status = ST_JOINED;
      end else begin
        if (parent == w.sender) begin
          // The parent got worse: follow its advertised cost, keep the parent.
          if (cost < w.cost) begin
            cost = clamp_add(w.cost, link);
            hops = clamp_add(w.hops, 8'd1);
          end
        end else if (cost > w.cost) begin
          cost = clamp_add(w.cost, link);
          hops = clamp_add(w.hops, 8'd1);
          r.data.old_next_hop  = parent;
          r.data.route_changed = 1'b1;
          parent = w.sender;
        end
        // Nine-bit sum so that the hop window never wraps.
        if ({1'b0, hops} + {1'b0, margin} > {1'b0, w.hops}) begin
          stamp = w.stamp;
          if (id_known(w.packet_id)) begin
            r.status = ST_DUPLICATE;
          end else begin
            remember_id(w.packet_id);
            r.data.rebroadcast = 1'b1;
            r.data.clear_slots = 1'b1;
            r.status = ST_NEW_BEACON;
          end
        end else begin
          r.status = ST_OUT_OF_RANGE;
        end
      end
      r.data.report_sender = w.sender;
      r.data.next_hop      = parent;
      r.data.route_hops    = hops;
      r.data.route_cost    = cost;
      r.data.sync_time     = stamp;
      pending_reports = {pending_reports, r};
    endfunction

    local function string describe(logic [2:0] st, route_word_t d);
      return $sformatf({"status=%0d sender=%h chg=%b old=%h next=%h hops=%0d cost=%0d",
                        " sync=%h rb=%b clr=%b pad=%h"},
                       st, d.report_sender, d.route_changed, d.old_next_hop, d.next_hop,
                       d.route_hops, d.route_cost, d.sync_time, d.rebroadcast, d.clear_slots,
                       d.pad);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d, logic [OUT_TUSER_W-1:0] u);
      route_report_t want;
      route_word_t got;
      got = d;
      if (pending_reports.size() == 0) begin
        fault($sformatf("unexpected result beat at %0t: %s", $realtime, describe(u, got)));
        return;
      end
      want = pending_reports.pop_front();
      if (u !== want.status || got !== want.data) begin
        fault($sformatf("mismatch at %0t\n  expected %s\n  actual   %s", $realtime,
                        describe(want.status, want.data), describe(u, got)));
      end
    endfunction

    function int pending();
      return pending_reports.size();
    endfunction

    // Any report still owed at the end is a failure.
    function void close();
      while (pending_reports.size() != 0) begin
        void'(pending_reports.pop_front());
        fault("route report never delivered");
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  route_scoreboard board;
  // calm turns off idling on both sides; hold_req asks the receiver for a long hold-off.
  bit calm = 0;
  bit hold_req = 0;

  beacon_route_update_core DUT (.*);

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Builds one input beat from its fields.
  function automatic rx_word_t beacon(node_mode_t m, logic s, logic c, logic [7:0] h,
                                      logic [31:0] st, logic [15:0] id, logic [7:0] co,
                                      logic [15:0] snd);
    rx_word_t w;
    w = '0;
    w.mode = m;
    w.sending = s;
    w.clean = c;
    w.hops = h;
    w.stamp = st;
    w.packet_id = id;
    w.cost = co;
    w.sender = snd;
    return w;
  endfunction

  // A value scattered around v by up to spread, clipped to the byte range.
  function automatic logic [7:0] near8(logic [7:0] v, int spread);
    int x;
    x = int'(v) + int'($urandom_range(0, 2 * spread)) - spread;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return x[7:0];
  endfunction

  // Most beats are well-formed beacons aimed at the interesting comparisons: senders
  // from a small pool or the current parent, costs near our own, hop counts near the
  // hop window edge, and packet ids from a pool a bit larger than the seen-id ring.
  task automatic make_beat(output rx_word_t w, output logic [7:0] mtype);
    int roll;
    logic [7:0] edge_hops;
    roll = $urandom_range(0, 99);
    w = '0;
    w.stamp = $urandom;
    if (roll < 80) begin
      if ($urandom_range(0, 1)) begin
        w.mode = MODE_LISTEN;
        w.sending = 1'($urandom_range(0, 1));
      end else begin
        w.mode = MODE_COMM;
        w.sending = 1'b0;
      end
      w.clean = 1'b1;
      mtype = board.type_code;
      roll = $urandom_range(0, 99);
      if (roll < 40)      w.sender = board.parent;
      else if (roll < 85) w.sender = 16'h0100 + 16'($urandom_range(0, 5));
      else                w.sender = 16'($urandom_range(0, 16'hFFFF));
      w.cost = ($urandom_range(0, 9) < 8) ? near8(board.cost, 12) : 8'($urandom_range(0, 255));
      edge_hops = (board.hops > 8'd255 - board.margin) ? 8'd255 : board.hops + board.margin;
      roll = $urandom_range(0, 9);
      if (roll < 5)      w.hops = near8(edge_hops, 3);
      else if (roll < 8) w.hops = near8(board.hops, 4);
      else               w.hops = 8'($urandom_range(0, 255));
      w.packet_id = ($urandom_range(0, 99) < 75) ? 16'hC000 + 16'($urandom_range(0, 23))
                                                 : 16'($urandom_range(0, 16'hFFFF));
    end else begin
      // Noise: every field at random, with the type right about half the time.
      w.mode = node_mode_t'(2'($urandom_range(0, 3)));
      w.sending = 1'($urandom_range(0, 1));
      w.clean = 1'($urandom_range(0, 1));
      mtype = $urandom_range(0, 1) ? board.type_code : 8'($urandom_range(0, 255));
      w.hops = 8'($urandom_range(0, 255));
      w.cost = 8'($urandom_range(0, 255));
      w.packet_id = 16'($urandom_range(0, 16'hFFFF));
      w.sender = 16'($urandom_range(0, 16'hFFFF));
    end
  endtask

  // Offers one beat, with random idle cycles ahead of it, and waits for the handshake.
  // Returns on the falling edge after the beat was taken, with valid still high.
  task automatic send_beat(input rx_word_t w, input logic [7:0] mtype);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= mtype;
    do @(posedge clk); while (!in_tready);
    board.note_beat(w, mtype);
    @(negedge clk);
  endtask

  task automatic run_traffic(input int count);
    rx_word_t w;
    logic [7:0] mtype;
    for (int i = 0; i < count; i++) begin
      make_beat(w, mtype);
      send_beat(w, mtype);
    end
  endtask

  // Stops offering beats and waits until every route report has come back and the
  // pipeline has settled. Ends on a falling edge.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes one register through the configuration channel; only called when idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    board = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed beats at the reset configuration (type 0, margin 4, link cost 5).
    // Radio cannot receive: sleeping, transmitting, communicating while sending.
    send_beat(beacon(MODE_SLEEP, 1'b0, 1'b1, 8'd3, 32'h1, 16'h0001, 8'd3, 16'h0042), 8'h00);
    send_beat(beacon(MODE_TX, 1'b1, 1'b1, 8'd3, 32'h1, 16'h0001, 8'd3, 16'h0042), 8'h00);
    send_beat(beacon(MODE_COMM, 1'b1, 1'b1, 8'd3, 32'h1, 16'h0001, 8'd3, 16'h0042), 8'h00);
    // Interference, then a wrong type while listening with the sending flag set.
    send_beat(beacon(MODE_LISTEN, 1'b0, 1'b0, 8'd3, 32'h1, 16'h0001, 8'd3, 16'h0042), 8'h00);
    send_beat(beacon(MODE_LISTEN, 1'b1, 1'b1, 8'd3, 32'h1, 16'h0001, 8'd3, 16'h0042), 8'hFF);
    // Join with the cost sum saturating at 255, the hop sum reaching 255, and all-ones fields.
    send_beat(beacon(MODE_COMM, 1'b0, 1'b1, 8'd254, 32'hFFFF_FFFF, 16'hFFFF, 8'd253,
                     16'hFFFF), 8'h00);
    // Same sender, equal cost: no reload, id already seen.
    send_beat(beacon(MODE_LISTEN, 1'b0, 1'b1, 8'd0, 32'h0, 16'hFFFF, 8'd255, 16'hFFFF), 8'h00);
    // Cheaper other sender: switch of next hop, new id.
    send_beat(beacon(MODE_LISTEN, 1'b0, 1'b1, 8'd0, 32'h1234_5678, 16'h0000, 8'd0, 16'h0000),
              8'h00);
    // Parent advertises a higher cost: reload cost and hops, keep the parent.
    send_beat(beacon(MODE_LISTEN, 1'b0, 1'b1, 8'd3, 32'h2, 16'h0000, 8'd10, 16'h0000), 8'h00);
    // Hop window edge: own hops 4 plus margin 4 is not above 8, but is above 7.
    send_beat(beacon(MODE_LISTEN, 1'b0, 1'b1, 8'd8, 32'h3, 16'h1234, 8'd200, 16'h1234), 8'h00);
    send_beat(beacon(MODE_LISTEN, 1'b0, 1'b1, 8'd7, 32'h4, 16'h1234, 8'd200, 16'h1234), 8'h00);
    send_beat(beacon(MODE_LISTEN, 1'b0, 1'b1, 8'd255, 32'h0, 16'h5555, 8'd200, 16'h1234), 8'h00);
    // Parent advertises a lower cost: nothing changes in the route.
    send_beat(beacon(MODE_LISTEN, 1'b0, 1'b1, 8'd2, 32'h5, 16'hBEEF, 8'd0, 16'h0000), 8'h00);
    drain();

    // Low extremes of margin and link cost, top type code.
    write_reg(CFG_BEACON_TYPE, 8'hFF);
    write_reg(CFG_HOP_MARGIN, 8'd0);
    write_reg(CFG_LINK_COST, 8'd0);
    run_traffic(300);
    drain();

    // High extremes; partway through, the receiver holds off so the block backs up.
    write_reg(CFG_BEACON_TYPE, 8'h5A);
    write_reg(CFG_HOP_MARGIN, 8'd255);
    write_reg(CFG_LINK_COST, 8'd255);
    run_traffic(100);
    hold_req = 1'b1;
    run_traffic(200);
    drain();

    // A write to the spare index must change nothing. This phase runs without idling.
    write_reg(CFG_SPARE_IDX, 8'hA5);
    write_reg(CFG_BEACON_TYPE, 8'h00);
    write_reg(CFG_HOP_MARGIN, 8'd1);
    write_reg(CFG_LINK_COST, 8'd1);
    calm = 1'b1;
    run_traffic(350);
    drain();
    calm = 1'b0;

    write_reg(CFG_BEACON_TYPE, 8'($urandom_range(0, 255)));
    write_reg(CFG_HOP_MARGIN, 8'($urandom_range(0, 255)));
    write_reg(CFG_LINK_COST, 8'($urandom_range(0, 255)));
    run_traffic(350);
    drain();

    write_reg(CFG_BEACON_TYPE, 8'($urandom_range(0, 255)));
    write_reg(CFG_HOP_MARGIN, 8'd4);
    write_reg(CFG_LINK_COST, 8'd5);
    run_traffic(350);
    drain();

    repeat (10) @(posedge clk);
    board.close();
    if (board.faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: checks each accepted result beat at the rising edge and chooses
  // the next ready at the falling edge. The long hold-off is counted here.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser);
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #(CLK_PERIOD * RUN_LIMIT_CYCLES);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bru_pkg.sv
design/bru_ctrl.sv
design/bru_dp.sv
design/beacon_route_update_core.sv
test/tb_top.sv
